FILE: rtl/core/two_tap_delay_pitch_shifter_macros.svh
// Assertion macros shared by the pitch shifter RTL.
`ifndef TWO_TAP_DELAY_PITCH_SHIFTER_MACROS_SVH
`define TWO_TAP_DELAY_PITCH_SHIFTER_MACROS_SVH

// Check that cons holds whenever ante holds, outside reset.
`define TTDPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds, outside reset.
`define TTDPS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/core/ttdps_pkg.sv
// Shared constants, register indexes and tables for the pitch shifter.
`default_nettype none
package ttdps_pkg;

  localparam int HISTORY_DEPTH_DEF = 8192;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int PHASE_BITS_DEF    = 32;

  localparam int WIN_W    = 12;
  localparam int SEMI_W   = 5;
  localparam int MIX_W    = 16;
  localparam int MAG_W    = 17;
  localparam int NUM_W    = 50;
  localparam int CFG_IDX_W = 2;
  localparam int WIN_MIN  = 64;
  localparam int MIX_ONE  = 32768;
  localparam int SEMI_LIM = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEMITONES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd3;

  localparam logic                     ENABLE_RST    = 1'b1;
  localparam logic signed [SEMI_W-1:0] SEMITONES_RST = -5'sd5;
  localparam logic [MIX_W-1:0]         MIX_LEVEL_RST = 16'd32768;
  localparam logic [WIN_W-1:0]         WINDOW_RST    = 12'd2400;

  // |1 - 2^(s/12)| in Q1.16 for s in -12..12
  function automatic logic [MAG_W-1:0] ratio_mag(input logic signed [SEMI_W-1:0] s);
    logic [MAG_W-1:0] m;
    case (s)
      -5'sd12: m = 17'd32768;
      -5'sd11: m = 17'd30820;
      -5'sd10: m = 17'd28755;
      -5'sd9:  m = 17'd26568;
      -5'sd8:  m = 17'd24251;
      -5'sd7:  m = 17'd21796;
      -5'sd6:  m = 17'd19195;
      -5'sd5:  m = 17'd16439;
      -5'sd4:  m = 17'd13520;
      -5'sd3:  m = 17'd10427;
      -5'sd2:  m = 17'd7150;
      -5'sd1:  m = 17'd3678;
      5'sd1:   m = 17'd3897;
      5'sd2:   m = 17'd8026;
      5'sd3:   m = 17'd12400;
      5'sd4:   m = 17'd17034;
      5'sd5:   m = 17'd21944;
      5'sd6:   m = 17'd27146;
      5'sd7:   m = 17'd32657;
      5'sd8:   m = 17'd38496;
      5'sd9:   m = 17'd44682;
      5'sd10:  m = 17'd51236;
      5'sd11:  m = 17'd58179;
      5'sd12:  m = 17'd65536;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] sin2_quarter(input logic [4:0] j);
    logic [15:0] v;
    case (j)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd79;
      5'd2:  v = 16'd315;
      5'd3:  v = 16'd705;
      5'd4:  v = 16'd1247;
      5'd5:  v = 16'd1935;
      5'd6:  v = 16'd2761;
      5'd7:  v = 16'd3719;
      5'd8:  v = 16'd4799;
      5'd9:  v = 16'd5990;
      5'd10: v = 16'd7282;
      5'd11: v = 16'd8661;
      5'd12: v = 16'd10114;
      5'd13: v = 16'd11628;
      5'd14: v = 16'd13188;
      5'd15: v = 16'd14778;
      5'd16: v = 16'd16384;
      default: v = '0;
    endcase
    return v;
  endfunction

  // sin^2 at point i of 64 per period, i in 0..64
  function automatic logic [15:0] weight_point(input logic [6:0] i);
    logic [6:0] j;
    logic [15:0] v;
    j = (i <= 7'd32) ? i : 7'd64 - i;
    if (j <= 7'd16) v = sin2_quarter(j[4:0]);
    else v = 16'd32768 - sin2_quarter(5'(7'd32 - j));
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ttdps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ttdps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/ttdps_div.sv
// Restoring divider, one quotient bit per cycle, for the phase step.
`default_nettype none
module ttdps_div #(
  parameter int NUMER_W = 50,
  parameter int DENOM_W = 28,
  parameter int QUO_W   = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NUMER_W-1:0] numer,
  input  wire logic [DENOM_W-1:0] denom,
  output logic                    busy,
  output logic [QUO_W-1:0]        quot
);
  localparam int CNT_W = $clog2(NUMER_W + 1);

  logic [DENOM_W-1:0] den;
  logic [DENOM_W-1:0] rem;
  logic [NUMER_W-1:0] num_sh;
  logic [NUMER_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic [DENOM_W:0]   trial;
  logic               fits;

  assign trial = {rem, num_sh[NUMER_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quot  = quo[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUMER_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den    <= denom;
      rem    <= '0;
      num_sh <= numer;
      quo    <= '0;
    end else if (busy) begin
      rem    <= fits ? DENOM_W'(trial - {1'b0, den}) : DENOM_W'(trial);
      num_sh <= {num_sh[NUMER_W-2:0], 1'b0};
      quo    <= {quo[NUMER_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/two_tap_delay_pitch_shifter.sv
// Top level: sequencer and datapath of the two-tap delay-line pitch shifter.
//
//  channel   direction  word
//  s_axis    in         tdata: left_in, right_in
//  m_axis    out        tdata: left_out, right_out
//  cfg       in         index 0 enable, 1 semitones, 2 mix_level, 3 window_len
//
// A processed word passes S_WRITE, S_IDX, S_READ, S_TAP, S_WET and S_OUT from accept to
// result, the four tap reads per word sharing the single read port of each history RAM.
// A bypassed word lands in the output register in the accept cycle.
// After reset both histories are cleared, one entry a cycle, then the phase step
// divider runs to completion; s_axis_tready is low until it is done.
// A write to semitones or window_len reruns the divider and holds s_axis_tready low.
`default_nettype none
module two_tap_delay_pitch_shifter #(
  parameter int HISTORY_DEPTH = ttdps_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = ttdps_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS    = ttdps_pkg::PHASE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // left_in, right_in, zero pad
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // left_out, right_out, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [ttdps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ttdps_pkg::MIX_W-1:0]     cfg_data
);
  localparam int SB      = SAMPLE_BITS;
  localparam int PB      = PHASE_BITS;
  localparam int TDATA_W = ((2*SB+7)/8)*8;
  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int SZ_W    = AW + 1;
  localparam int IW      = AW + 2;
  localparam int WW      = ttdps_pkg::WIN_W;
  localparam int PROD_W  = PB + WW;
  localparam int WIN_MAX = (HISTORY_DEPTH - 4) / 2;
  localparam int DEN_W   = WW + 48 - PB;
  localparam int IV_W    = SB + 19;
  localparam int WT_W    = SB + 18;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_WRITE = 8'b0000_0100,
    S_IDX   = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_TAP   = 8'b0010_0000,
    S_WET   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  logic                                    enable;
  logic signed [ttdps_pkg::SEMI_W-1:0]     semitones;
  logic [ttdps_pkg::MIX_W-1:0]             mix_level;
  logic [WW-1:0]                           window_len;

  logic [WW-1:0]                           win;
  logic [SZ_W-1:0]                         size;
  logic signed [ttdps_pkg::SEMI_W-1:0]     semi_c;
  logic [ttdps_pkg::MAG_W-1:0]             mag;
  logic                                    step_neg;
  logic                                    bypass;
  logic [16:0]                             mix;
  logic [16:0]                             dry;

  logic                                    div_pending;
  logic                                    div_start;
  logic                                    div_busy;
  logic                                    div_wait;
  logic [DEN_W-1:0]                        denom;
  logic [ttdps_pkg::NUM_W-1:0]             numer;
  logic [PB-1:0]                           quot;
  logic [PB-1:0]                           step;

  logic [AW-1:0]                           clr_cnt;
  logic [AW-1:0]                           wp;
  logic [AW-1:0]                           wr_addr;
  logic [PB-1:0]                           phase;
  logic [PB-1:0]                           phase_b;
  logic signed [SB-1:0]                    xl;
  logic signed [SB-1:0]                    xr;
  logic signed [SB-1:0]                    in_l;
  logic signed [SB-1:0]                    in_r;
  logic [PROD_W-1:0]                       prod_a;
  logic [PROD_W-1:0]                       prod_b;
  logic [15:0]                             wa;
  logic [15:0]                             wa_next;
  logic [15:0]                             wb;
  logic [AW-1:0]                           i0a;
  logic [AW-1:0]                           i1a;
  logic [AW-1:0]                           i0b;
  logic [AW-1:0]                           i1b;
  logic [16:0]                             f2a;
  logic [16:0]                             f2b;
  logic [2:0]                              rd_cnt;
  logic signed [SB-1:0]                    hl [4];
  logic signed [SB-1:0]                    hr [4];
  logic signed [SB-1:0]                    tla;
  logic signed [SB-1:0]                    tlb;
  logic signed [SB-1:0]                    tra;
  logic signed [SB-1:0]                    trb;
  logic signed [SB-1:0]                    wet_l;
  logic signed [SB-1:0]                    wet_r;
  logic signed [SB-1:0]                    out_l;
  logic signed [SB-1:0]                    out_r;
  logic                                    out_valid;
  logic                                    out_load;
  logic                                    in_fire;

  logic                                    ram_we;
  logic [AW-1:0]                           ram_waddr;
  logic [SB-1:0]                           ram_wdata_l;
  logic [SB-1:0]                           ram_wdata_r;
  logic [AW-1:0]                           ram_raddr;
  logic [SB-1:0]                           ram_rdata_l;
  logic [SB-1:0]                           ram_rdata_r;

  logic [5:0]                              wi;
  logic [9:0]                              wf;
  logic [26:0]                             wsum;
  logic [AW-1:0]                           i0a_next;
  logic [AW-1:0]                           i1a_next;
  logic [AW-1:0]                           i0b_next;
  logic [AW-1:0]                           i1b_next;
  logic [16:0]                             f2a_next;
  logic [16:0]                             f2b_next;

  function automatic logic signed [SB-1:0] interp(input logic signed [SB-1:0] h0,
                                                  input logic signed [SB-1:0] h1,
                                                  input logic [16:0] f2);
    logic [17:0] g;
    logic signed [IV_W-1:0] v;
    g = 18'd65536 - {1'b0, f2};
    v = IV_W'(h0 * $signed(g)) + IV_W'(h1 * $signed({1'b0, f2}));
    v = (v + IV_W'(32768)) >>> 16;
    return v[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] weigh(input logic signed [SB-1:0] ta,
                                                 input logic signed [SB-1:0] tb,
                                                 input logic [15:0] a,
                                                 input logic [15:0] b);
    logic signed [WT_W-1:0] v;
    v = WT_W'(ta * $signed({1'b0, a})) + WT_W'(tb * $signed({1'b0, b}));
    v = (v + WT_W'(16384)) >>> 15;
    return v[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] blend(input logic signed [SB-1:0] x,
                                                 input logic signed [SB-1:0] w,
                                                 input logic [16:0] d,
                                                 input logic [16:0] m);
    logic signed [WT_W-1:0] v;
    logic signed [SB-1:0]   r;
    v = WT_W'(x * $signed({1'b0, d})) + WT_W'(w * $signed({1'b0, m}));
    v = (v + WT_W'(16384)) >>> 15;
    if (v > WT_W'((2**(SB-1)) - 1)) r = {1'b0, {(SB-1){1'b1}}};
    else if (v < -WT_W'(2**(SB-1))) r = {1'b1, {(SB-1){1'b0}}};
    else r = v[SB-1:0];
    return r;
  endfunction

  // map a tap product to its two history indexes and interpolation weight
  function automatic logic [AW+AW+17-1:0] tap_index(input logic [PROD_W-1:0] p,
                                                    input logic [AW-1:0] wpn,
                                                    input logic [SZ_W-1:0] sz);
    logic [WW-1:0] dint;
    logic [15:0]   fr;
    logic          carry;
    logic [16:0]   f2;
    logic [IW-1:0] t;
    logic [AW-1:0] i0;
    logic [SZ_W-1:0] i1w;
    logic [AW-1:0] i1;
    dint  = p[PB +: WW];
    fr    = p[PB-16 +: 16];
    carry = fr != 16'd0;
    f2    = carry ? 17'd65536 - {1'b0, fr} : 17'd0;
    t     = IW'(wpn) + IW'(sz) - IW'(1) - IW'(dint) - IW'(carry);
    if (t >= IW'(sz)) t = t - IW'(sz);
    i0    = t[AW-1:0];
    i1w   = SZ_W'(i0) + SZ_W'(1);
    i1    = (i1w == sz) ? '0 : i1w[AW-1:0];
    return {i0, i1, f2};
  endfunction

  assign cfg_ready = 1'b1;
  assign in_l = $signed(s_axis_tdata[0 +: SB]);
  assign in_r = $signed(s_axis_tdata[SB +: SB]);

  always_comb begin
    win = window_len;
    if (window_len < WW'(ttdps_pkg::WIN_MIN)) win = WW'(ttdps_pkg::WIN_MIN);
    else if (32'(window_len) > WIN_MAX) win = WW'(WIN_MAX);
    size = SZ_W'(2 * 32'(win) + 4);

    semi_c = semitones;
    if (semitones > 5'(ttdps_pkg::SEMI_LIM)) semi_c = 5'(ttdps_pkg::SEMI_LIM);
    else if (semitones < -5'(ttdps_pkg::SEMI_LIM)) semi_c = -5'(ttdps_pkg::SEMI_LIM);
    mag      = ttdps_pkg::ratio_mag(semi_c);
    step_neg = semi_c > 5'sd0;
    bypass   = !enable || (semitones == 5'sd0);

    mix = (mix_level > 16'(ttdps_pkg::MIX_ONE)) ? 17'(ttdps_pkg::MIX_ONE) : 17'(mix_level);
    dry = 17'(ttdps_pkg::MIX_ONE) - mix;
  end

  assign denom     = DEN_W'(win) << (48 - PB);
  assign numer     = ttdps_pkg::NUM_W'({mag, 32'd0}) + ttdps_pkg::NUM_W'(denom >> 1);
  assign div_start = div_pending && (state != S_CLEAR);
  assign div_wait  = div_pending || div_busy;
  assign step      = step_neg ? PB'(0) - quot : quot;

  ttdps_div #(
    .NUMER_W (ttdps_pkg::NUM_W),
    .DENOM_W (DEN_W),
    .QUO_W   (PB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (denom),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= ttdps_pkg::ENABLE_RST;
      semitones   <= ttdps_pkg::SEMITONES_RST;
      mix_level   <= ttdps_pkg::MIX_LEVEL_RST;
      window_len  <= ttdps_pkg::WINDOW_RST;
      div_pending <= 1'b1;
    end else begin
      if (div_start) begin
        div_pending <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ttdps_pkg::REG_ENABLE:    enable <= cfg_data[0];
          ttdps_pkg::REG_SEMITONES: begin
            semitones   <= $signed(cfg_data[ttdps_pkg::SEMI_W-1:0]);
            div_pending <= 1'b1;
          end
          ttdps_pkg::REG_MIX_LEVEL: mix_level <= cfg_data;
          ttdps_pkg::REG_WINDOW: begin
            window_len  <= cfg_data[WW-1:0];
            div_pending <= 1'b1;
          end
          default: enable <= enable;
        endcase
      end
    end
  end

  assign s_axis_tready = (state == S_IDLE) && !div_wait &&
                         (!bypass || !out_valid || m_axis_tready);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (in_fire && bypass) ||
                    ((state == S_OUT) && (!out_valid || m_axis_tready));

  assign phase_b = phase + {1'b1, {(PB-1){1'b0}}};
  assign wb      = 16'(ttdps_pkg::MIX_ONE) - wa;

  always_comb begin
    wi   = phase[PB-1 -: 6];
    wf   = phase[PB-7 -: 10];
    wsum = 27'(ttdps_pkg::weight_point({1'b0, wi})) * 27'(11'd1024 - {1'b0, wf}) +
           27'(ttdps_pkg::weight_point(7'({1'b0, wi}) + 7'd1)) * 27'(wf) + 27'd512;
    wa_next = wsum[25:10];
    {i0a_next, i1a_next, f2a_next} = tap_index(prod_a, wp, size);
    {i0b_next, i1b_next, f2b_next} = tap_index(prod_b, wp, size);
  end

  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    ram_raddr = i0a;
      2'd1:    ram_raddr = i1a;
      2'd2:    ram_raddr = i0b;
      default: ram_raddr = i1b;
    endcase
  end

  assign ram_we      = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_waddr   = (state == S_CLEAR) ? clr_cnt : wr_addr;
  assign ram_wdata_l = (state == S_CLEAR) ? '0 : xl;
  assign ram_wdata_r = (state == S_CLEAR) ? '0 : xr;

  ttdps_ram #(.WIDTH(SB), .DEPTH(HISTORY_DEPTH)) u_hist_l (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata_l),
    .raddr (ram_raddr),
    .rdata (ram_rdata_l)
  );

  ttdps_ram #(.WIDTH(SB), .DEPTH(HISTORY_DEPTH)) u_hist_r (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      wp        <= '0;
      phase     <= '0;
      rd_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(HISTORY_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire && !bypass) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          wp    <= (SZ_W'(wr_addr) + SZ_W'(1) >= size) ? '0 : wr_addr + 1'b1;
          state <= S_IDX;
        end
        S_IDX: begin
          rd_cnt <= '0;
          state  <= S_READ;
        end
        S_READ: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == 3'd4) state <= S_TAP;
        end
        S_TAP:   state <= S_WET;
        S_WET:   state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            phase <= phase + step;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      xl      <= in_l;
      xr      <= in_r;
      wr_addr <= (SZ_W'(wp) >= size) ? '0 : wp;
    end
    if (state == S_WRITE) begin
      prod_a <= PROD_W'(phase) * PROD_W'(win);
      prod_b <= PROD_W'(phase_b) * PROD_W'(win);
      wa     <= wa_next;
    end
    if (state == S_IDX) begin
      i0a <= i0a_next;
      i1a <= i1a_next;
      f2a <= f2a_next;
      i0b <= i0b_next;
      i1b <= i1b_next;
      f2b <= f2b_next;
    end
    if ((state == S_READ) && (rd_cnt != 3'd0)) begin
      hl[0] <= hl[1];
      hl[1] <= hl[2];
      hl[2] <= hl[3];
      hl[3] <= $signed(ram_rdata_l);
      hr[0] <= hr[1];
      hr[1] <= hr[2];
      hr[2] <= hr[3];
      hr[3] <= $signed(ram_rdata_r);
    end
    if (state == S_TAP) begin
      tla <= interp(hl[0], hl[1], f2a);
      tlb <= interp(hl[2], hl[3], f2b);
      tra <= interp(hr[0], hr[1], f2a);
      trb <= interp(hr[2], hr[3], f2b);
    end
    if (state == S_WET) begin
      wet_l <= weigh(tla, tlb, wa, wb);
      wet_r <= weigh(tra, trb, wa, wb);
    end
    if (out_load) begin
      if (state == S_OUT) begin
        out_l <= blend(xl, wet_l, dry, mix);
        out_r <= blend(xr, wet_r, dry, mix);
      end else begin
        out_l <= in_l;
        out_r <= in_r;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'({out_r, out_l});

`include "two_tap_delay_pitch_shifter_macros.svh"

  `TTDPS_ASSERT_IMP(a_no_accept_div, in_fire, !div_wait, "word accepted while step divider busy")
  `TTDPS_ASSERT_IMP(a_clear_blocks, state == S_CLEAR, !s_axis_tready, "ready during history clear")
  `TTDPS_ASSERT_IMP(a_we_state, ram_we, (state == S_CLEAR) || (state == S_WRITE), "stray RAM write")
  `TTDPS_ASSERT_NEVER(a_wp_range, SZ_W'(wp) >= SZ_W'(HISTORY_DEPTH), "write pointer out of range")
  `TTDPS_ASSERT_IMP(a_out_commit, (state == S_OUT) && out_load, ##1 (state == S_IDLE) && m_axis_tvalid, "result not presented")

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the two-tap delay-line pitch shifter.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 8192;
  localparam int WIN_MAX = (DEPTH - 4) / 2;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ttdps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ttdps_pkg::MIX_W-1:0] cfg_data = '0;

  two_tap_delay_pitch_shifter dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  int hist_l [DEPTH];
  int hist_r [DEPTH];
  int unsigned wr_ptr;
  logic [31:0] phase;
  logic cur_enable;
  logic [4:0] cur_semi;
  logic [15:0] cur_mix;
  logic [11:0] cur_win;

  const int ratio_tbl [25] = '{32768, 34716, 36781, 38968, 41285, 43740, 46341, 49097,
    52016, 55109, 58386, 61858, 65536, 69433, 73562, 77936, 82570, 87480, 92682,
    98193, 104032, 110218, 116772, 123715, 131072};
  const int quarter_tbl [17] = '{0, 79, 315, 705, 1247, 1935, 2761, 3719, 4799,
    5990, 7282, 8661, 10114, 11628, 13188, 14778, 16384};

  frame_t expected_q[$];
  int errors = 0;
  bit calm = 0;
  int stall_left = 0;

  function automatic longint rnd(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic int sin2_at(int i);
    int j;
    j = (i <= 32) ? i : 64 - i;
    return (j <= 16) ? quarter_tbl[j] : 32768 - quarter_tbl[32 - j];
  endfunction

  function automatic longint tap_gain(logic [31:0] ph);
    int i, f;
    i = ph[31:26];
    f = ph[25:16];
    return (sin2_at(i) * (1024 - f) + sin2_at(i + 1) * f + 512) >> 10;
  endfunction

  function automatic longint tap_sample(bit right, int size, int wpn, logic [31:0] ph,
                                        int win);
    logic [63:0] prod;
    int dint, fr, carry, f2, i0, i1;
    longint v;
    prod = {32'b0, ph} * 64'(win);
    dint = prod[63:32];
    fr = prod[31:16];
    carry = (fr != 0);
    f2 = carry ? 65536 - fr : 0;
    i0 = (wpn + size - 1 - dint - carry) % size;
    i1 = (i0 + 1) % size;
    if (right) v = longint'(hist_r[i0]) * (65536 - f2) + longint'(hist_r[i1]) * f2;
    else v = longint'(hist_l[i0]) * (65536 - f2) + longint'(hist_l[i1]) * f2;
    return rnd(v, 16);
  endfunction

  function automatic logic signed [15:0] sat16(longint x);
    return (x > 32767) ? 16'sh7fff : (x < -32768) ? 16'sh8000 : 16'(x);
  endfunction

  function automatic frame_t shift_frame(frame_t x);
    frame_t y;
    int semi, win, size, wp, wpn, diff;
    longint mag, smag, wa, wb, wetl, wetr, mix;
    logic [31:0] phb;
    semi = int'(signed'(cur_semi));
    if (!cur_enable || semi == 0) return x;
    if (semi > 12) semi = 12;
    if (semi < -12) semi = -12;
    win = cur_win;
    if (win < 64) win = 64;
    if (win > WIN_MAX) win = WIN_MAX;
    size = 2 * win + 4;
    diff = 65536 - ratio_tbl[semi + 12];
    mag = (diff < 0) ? -diff : diff;
    smag = ((mag << 32) + ((longint'(win) << 16) / 2)) / (longint'(win) << 16);
    wp = wr_ptr;
    if (wp >= size) wp = 0;
    hist_l[wp] = x.left;
    hist_r[wp] = x.right;
    wpn = wp + 1;
    if (wpn >= size) wpn = 0;
    wr_ptr = wpn;
    phb = phase + 32'h8000_0000;
    wa = tap_gain(phase);
    wb = 32768 - wa;
    wetl = rnd(tap_sample(0, size, wpn, phase, win) * wa +
               tap_sample(0, size, wpn, phb, win) * wb, 15);
    wetr = rnd(tap_sample(1, size, wpn, phase, win) * wa +
               tap_sample(1, size, wpn, phb, win) * wb, 15);
    phase = (diff < 0) ? phase - 32'(smag) : phase + 32'(smag);
    mix = (cur_mix > 16'd32768) ? 32768 : cur_mix;
    y.left = sat16(rnd(longint'(x.left) * (32768 - mix) + wetl * mix, 15));
    y.right = sat16(rnd(longint'(x.right) * (32768 - mix) + wetr * mix, 15));
    return y;
  endfunction

  task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r);
    frame_t x;
    x.left = l;
    x.right = r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, l};
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(shift_frame(x));
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [ttdps_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ttdps_pkg::REG_ENABLE: cur_enable = value[0];
      ttdps_pkg::REG_SEMITONES: cur_semi = value[4:0];
      ttdps_pkg::REG_MIX_LEVEL: cur_mix = value[15:0];
      ttdps_pkg::REG_WINDOW: cur_win = value[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup(int en, int semi, int mix, int win);
    drain();
    write_reg(ttdps_pkg::REG_ENABLE, en);
    write_reg(ttdps_pkg::REG_SEMITONES, semi);
    write_reg(ttdps_pkg::REG_MIX_LEVEL, mix);
    write_reg(ttdps_pkg::REG_WINDOW, win);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_defaults();
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0000, -16'sh1);
    send_frame(16'shaaaa, 16'sh5555);
    send_frame(16'sh5555, 16'shaaaa);
  endtask

  task automatic test_bypass();
    setup(0, 7, 20000, 100);
    send_frame(16'sh1234, 16'sh8000);
    send_frame(16'sh7fff, 16'sh0001);
    setup(1, 0, 20000, 100);
    send_frame(16'sh4321, 16'shffff);
    send_frame(16'sh8000, 16'sh7fff);
  endtask

  task automatic test_clamps();
    setup(1, 15, 65535, 0);
    repeat (4) send_frame(rand_sample(), rand_sample());
    setup(1, 16, 32769, 4095);
    repeat (140) send_frame(rand_sample(), rand_sample());
    // shrink the window so the write position lands past the new history
    setup(1, -12, 0, 63);
    repeat (3) send_frame(16'sh7fff, 16'sh8000);
  endtask

  task automatic test_random();
    int n;
    for (int p = 0; p < 11; p++) begin
      if (p == 10) calm = 1;
      setup($urandom_range(0, 7) != 0, $urandom_range(0, 31), $urandom_range(0, 9) == 0 ?
            $urandom_range(0, 65535) : $urandom_range(0, 32768),
            $urandom_range(0, 5) == 0 ? $urandom_range(0, 4095) : $urandom_range(64, 300));
      n = 88;
      for (int k = 0; k < n; k++) begin
        maybe_gap();
        send_frame(rand_sample(), rand_sample());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[15:0] !== want.left || m_axis_tdata[31:16] !== want.right) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d", want.left,
                     want.right, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      hist_l[i] = 0;
      hist_r[i] = 0;
    end
    wr_ptr = 0;
    phase = '0;
    cur_enable = ttdps_pkg::ENABLE_RST;
    cur_semi = ttdps_pkg::SEMITONES_RST;
    cur_mix = ttdps_pkg::MIX_LEVEL_RST;
    cur_win = ttdps_pkg::WINDOW_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_bypass();
    test_clamps();
    test_random();
    drain();
    if (errors == 0 && expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
